// File: hdl/vcrt_pkg.sv
// Shared constants and types for the vertex colour and rotate transform block.
package vcrt_pkg;

    localparam int PIPE_DEPTH = 10;

    localparam int ROT_FRAC  = 14;
    localparam int ROT_HALF  = 8192;
    localparam int Q8_FRAC   = 8;
    localparam int Q8_HALF   = 128;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int COLOR_W    = 24;
    localparam int OUT_W      = 32;

    localparam logic [47:0] OFFSET_RST  = 48'h0;
    localparam logic [31:0] GAIN_RST    = 32'h0100_0100;
    localparam logic [31:0] ROTATE_RST  = 32'h0000_4000;
    localparam logic [15:0] TOP_RST     = 16'h0;
    localparam logic [47:0] PALETTE_RST = 48'h0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OFFSET_XYZ   = 3'd0,
        CFG_GAIN_PAIR    = 3'd1,
        CFG_ROTATE_X     = 3'd2,
        CFG_ROTATE_Y     = 3'd3,
        CFG_ROTATE_Z     = 3'd4,
        CFG_TOP_ALTITUDE = 3'd5,
        CFG_PALETTE_LOW  = 3'd6,
        CFG_PALETTE_HIGH = 3'd7
    } t_cfg_reg;

endpackage

// File: hdl/vertex_color_rotate_transform_unit.sv
// Vertex colour band, offset, altitude gain, XYZ rotation and zoom pipeline.
// Throughput: one vertex per cycle while the output is not stalled; ten-stage multiply/round pipeline.
// A stalled output holds; empty stages further up still fill, so input stalls
// only once every stage is occupied.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
module vertex_color_rotate_transform_unit
    import vcrt_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_map_x,
    input  logic signed [COORD_WIDTH-1:0] i_map_y,
    input  logic signed [COORD_WIDTH-1:0] i_altitude,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [OUT_W-1:0]       o_screen_x,
    output logic signed [OUT_W-1:0]       o_screen_y,
    output logic signed [OUT_W-1:0]       o_depth_z,
    output logic [COLOR_W-1:0]            o_vertex_color
);

    localparam int CW   = COORD_WIDTH;
    localparam int W0   = CW + 9;
    localparam int WG   = W0 + 17;
    localparam int N1   = CW + 18;
    localparam int PW1  = N1 + 16;
    localparam int SW1  = N1 + 17;
    localparam int R1   = N1 + 3;
    localparam int PW2  = R1 + 16;
    localparam int SW2  = R1 + 17;
    localparam int R2   = R1 + 3;
    localparam int PW3  = R2 + 16;
    localparam int SW3  = R2 + 17;
    localparam int R3   = R2 + 3;
    localparam int ZPW  = R3 + 17;
    localparam int CMPW = (CW + 5 > 20) ? CW + 5 : 20;

    // configuration registers
    logic [47:0] r_offset;
    logic [31:0] r_gain;
    logic [31:0] r_rot_x;
    logic [31:0] r_rot_y;
    logic [31:0] r_rot_z;
    logic [15:0] r_top;
    logic [47:0] r_pal_lo;
    logic [47:0] r_pal_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RST;
            r_gain   <= GAIN_RST;
            r_rot_x  <= ROTATE_RST;
            r_rot_y  <= ROTATE_RST;
            r_rot_z  <= ROTATE_RST;
            r_top    <= TOP_RST;
            r_pal_lo <= PALETTE_RST;
            r_pal_hi <= PALETTE_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_OFFSET_XYZ:   r_offset <= i_cfg_wdata;
                CFG_GAIN_PAIR:    r_gain   <= i_cfg_wdata[31:0];
                CFG_ROTATE_X:     r_rot_x  <= i_cfg_wdata[31:0];
                CFG_ROTATE_Y:     r_rot_y  <= i_cfg_wdata[31:0];
                CFG_ROTATE_Z:     r_rot_z  <= i_cfg_wdata[31:0];
                CFG_TOP_ALTITUDE: r_top    <= i_cfg_wdata[15:0];
                CFG_PALETTE_LOW:  r_pal_lo <= i_cfg_wdata;
                CFG_PALETTE_HIGH: r_pal_hi <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [15:0] w_off_x, w_off_y, w_off_z, w_top;
    logic signed [15:0] w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;
    logic signed [16:0] w_gain, w_zoom;

    assign w_off_x = $signed(r_offset[15:0]);
    assign w_off_y = $signed(r_offset[31:16]);
    assign w_off_z = $signed(r_offset[47:32]);
    assign w_top   = $signed(r_top);
    assign w_cx    = $signed(r_rot_x[15:0]);
    assign w_sx    = $signed(r_rot_x[31:16]);
    assign w_cy    = $signed(r_rot_y[15:0]);
    assign w_sy    = $signed(r_rot_y[31:16]);
    assign w_cz    = $signed(r_rot_z[15:0]);
    assign w_sz    = $signed(r_rot_z[31:16]);
    assign w_gain  = $signed({1'b0, r_gain[15:0]});
    assign w_zoom  = $signed({1'b0, r_gain[31:16]});

    // pipeline flow control: a stage loads when empty or when the next one moves
    logic [PIPE_DEPTH:1] r_vld;
    logic [PIPE_DEPTH:1] n_vld;
    logic [PIPE_DEPTH:1] w_en;

    always_comb begin
        w_en[PIPE_DEPTH] = !r_vld[PIPE_DEPTH] || !i_stall;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[1] = w_en[1] ? i_valid : r_vld[1];
        for (int k = 2; k <= PIPE_DEPTH; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_en[1];
    assign o_valid = r_vld[PIPE_DEPTH];

    // stage 1: offsets and colour band
    logic signed [CMPW-1:0] w_alt10, w_top7, w_top4;
    logic [COLOR_W-1:0]     w_color;
    logic signed [W0-1:0]   w_s1_x, w_s1_y, w_s1_z;

    assign w_alt10 = CMPW'(i_altitude) * CMPW'(10);
    assign w_top7  = CMPW'(w_top) * CMPW'(7);
    assign w_top4  = CMPW'(w_top) * CMPW'(4);

    always_comb begin
        if (w_alt10 > w_top7) begin
            w_color = r_pal_hi[47:24];
        end else if (w_alt10 > w_top4) begin
            w_color = r_pal_hi[23:0];
        end else if (i_altitude < 0) begin
            w_color = r_pal_lo[23:0];
        end else begin
            w_color = r_pal_lo[47:24];
        end
    end

    assign w_s1_x = (W0'(i_map_x) <<< Q8_FRAC) + W0'(w_off_x);
    assign w_s1_y = (W0'(i_map_y) <<< Q8_FRAC) + W0'(w_off_y);
    assign w_s1_z = (W0'(i_altitude) <<< Q8_FRAC) + W0'(w_off_z);

    logic signed [W0-1:0]  r_s1_x, r_s1_y, r_s1_z;
    logic [COLOR_W-1:0]    r_s1_col;
    // stage 2: altitude gain
    logic signed [W0-1:0]  r_s2_x, r_s2_y;
    logic signed [WG-1:0]  r_s2_zg;
    logic [COLOR_W-1:0]    r_s2_col;
    // stage 3: X rotation products
    logic signed [W0-1:0]  r_s3_x;
    logic signed [PW1-1:0] r_s3_yc, r_s3_zs, r_s3_ys, r_s3_zc;
    logic [COLOR_W-1:0]    r_s3_col;
    // stage 4: X rotation sums
    logic signed [W0-1:0]  r_s4_x;
    logic signed [SW1-1:0] r_s4_ya, r_s4_za;
    logic [COLOR_W-1:0]    r_s4_col;
    // stage 5: Y rotation products
    logic signed [R1-1:0]  r_s5_y;
    logic signed [PW2-1:0] r_s5_xc, r_s5_zs, r_s5_xs, r_s5_zc;
    logic [COLOR_W-1:0]    r_s5_col;
    // stage 6: Y rotation sums
    logic signed [R1-1:0]  r_s6_y;
    logic signed [SW2-1:0] r_s6_xa, r_s6_za;
    logic [COLOR_W-1:0]    r_s6_col;
    // stage 7: Z rotation products
    logic signed [R2-1:0]  r_s7_z;
    logic signed [PW3-1:0] r_s7_xc, r_s7_ys, r_s7_xs, r_s7_yc;
    logic [COLOR_W-1:0]    r_s7_col;
    // stage 8: Z rotation sums
    logic signed [R2-1:0]  r_s8_z;
    logic signed [SW3-1:0] r_s8_xa, r_s8_ya;
    logic [COLOR_W-1:0]    r_s8_col;
    // stage 9: zoom products
    logic signed [ZPW-1:0] r_s9_xp, r_s9_yp, r_s9_zp;
    logic [COLOR_W-1:0]    r_s9_col;
    // stage 10: round, saturate, output register
    logic signed [OUT_W-1:0] r_s10_x, r_s10_y, r_s10_z;
    logic [COLOR_W-1:0]      r_s10_col;

    logic signed [WG-1:0]  w_zg_rnd;
    logic signed [N1-1:0]  w_s3_y, w_s3_z;
    logic signed [R1-1:0]  w_s5_x, w_s5_y, w_s5_z;
    logic signed [R2-1:0]  w_s7_x, w_s7_y, w_s7_z;
    logic signed [R3-1:0]  w_s9_x, w_s9_y, w_s9_z;
    logic signed [ZPW-1:0] w_xr, w_yr, w_zr;

    assign w_zg_rnd = r_s2_zg + WG'(Q8_HALF);
    assign w_s3_z   = N1'(w_zg_rnd >>> Q8_FRAC);
    assign w_s3_y   = N1'(r_s2_y);

    assign w_s5_x = R1'(r_s4_x);
    assign w_s5_y = R1'(r_s4_ya >>> ROT_FRAC);
    assign w_s5_z = R1'(r_s4_za >>> ROT_FRAC);

    assign w_s7_x = R2'(r_s6_xa >>> ROT_FRAC);
    assign w_s7_y = R2'(r_s6_y);
    assign w_s7_z = R2'(r_s6_za >>> ROT_FRAC);

    assign w_s9_x = R3'(r_s8_xa >>> ROT_FRAC);
    assign w_s9_y = R3'(r_s8_ya >>> ROT_FRAC);
    assign w_s9_z = R3'(r_s8_z);

    assign w_xr = (r_s9_xp + ZPW'(Q8_HALF)) >>> Q8_FRAC;
    assign w_yr = (r_s9_yp + ZPW'(Q8_HALF)) >>> Q8_FRAC;
    assign w_zr = (r_s9_zp + ZPW'(Q8_HALF)) >>> Q8_FRAC;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ZPW-1:0] v);
        logic [ZPW-OUT_W:0] top_bits;
        top_bits = v[ZPW-1:OUT_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            sat_out = v[OUT_W-1:0];
        end else if (v[ZPW-1]) begin
            sat_out = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat_out = {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_x   <= w_s1_x;
            r_s1_y   <= w_s1_y;
            r_s1_z   <= w_s1_z;
            r_s1_col <= w_color;
        end
        if (w_en[2]) begin
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_zg  <= WG'(r_s1_z) * WG'(w_gain);
            r_s2_col <= r_s1_col;
        end
        if (w_en[3]) begin
            r_s3_x   <= r_s2_x;
            r_s3_yc  <= PW1'(w_s3_y) * PW1'(w_cx);
            r_s3_zs  <= PW1'(w_s3_z) * PW1'(w_sx);
            r_s3_ys  <= PW1'(w_s3_y) * PW1'(w_sx);
            r_s3_zc  <= PW1'(w_s3_z) * PW1'(w_cx);
            r_s3_col <= r_s2_col;
        end
        if (w_en[4]) begin
            r_s4_x   <= r_s3_x;
            r_s4_ya  <= SW1'(r_s3_yc) - SW1'(r_s3_zs) + SW1'(ROT_HALF);
            r_s4_za  <= SW1'(r_s3_ys) + SW1'(r_s3_zc) + SW1'(ROT_HALF);
            r_s4_col <= r_s3_col;
        end
        if (w_en[5]) begin
            r_s5_y   <= w_s5_y;
            r_s5_xc  <= PW2'(w_s5_x) * PW2'(w_cy);
            r_s5_zs  <= PW2'(w_s5_z) * PW2'(w_sy);
            r_s5_xs  <= PW2'(w_s5_x) * PW2'(w_sy);
            r_s5_zc  <= PW2'(w_s5_z) * PW2'(w_cy);
            r_s5_col <= r_s4_col;
        end
        if (w_en[6]) begin
            r_s6_y   <= r_s5_y;
            r_s6_xa  <= SW2'(r_s5_xc) + SW2'(r_s5_zs) + SW2'(ROT_HALF);
            r_s6_za  <= SW2'(r_s5_zc) - SW2'(r_s5_xs) + SW2'(ROT_HALF);
            r_s6_col <= r_s5_col;
        end
        if (w_en[7]) begin
            r_s7_z   <= w_s7_z;
            r_s7_xc  <= PW3'(w_s7_x) * PW3'(w_cz);
            r_s7_ys  <= PW3'(w_s7_y) * PW3'(w_sz);
            r_s7_xs  <= PW3'(w_s7_x) * PW3'(w_sz);
            r_s7_yc  <= PW3'(w_s7_y) * PW3'(w_cz);
            r_s7_col <= r_s6_col;
        end
        if (w_en[8]) begin
            r_s8_z   <= r_s7_z;
            r_s8_xa  <= SW3'(r_s7_xc) - SW3'(r_s7_ys) + SW3'(ROT_HALF);
            r_s8_ya  <= SW3'(r_s7_xs) + SW3'(r_s7_yc) + SW3'(ROT_HALF);
            r_s8_col <= r_s7_col;
        end
        if (w_en[9]) begin
            r_s9_xp  <= ZPW'(w_s9_x) * ZPW'(w_zoom);
            r_s9_yp  <= ZPW'(w_s9_y) * ZPW'(w_zoom);
            r_s9_zp  <= ZPW'(w_s9_z) * ZPW'(w_zoom);
            r_s9_col <= r_s8_col;
        end
        if (w_en[10]) begin
            r_s10_x   <= sat_out(w_xr);
            r_s10_y   <= sat_out(w_yr);
            r_s10_z   <= sat_out(w_zr);
            r_s10_col <= r_s9_col;
        end
    end

    assign o_screen_x     = r_s10_x;
    assign o_screen_y     = r_s10_y;
    assign o_depth_z      = r_s10_z;
    assign o_vertex_color = r_s10_col;

    // input only stalls once the whole pipeline is backed up
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld) && i_stall)
        else $error("input stalled while a stage is free");

    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled with output draining");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[1])
        else $error("accepted transaction lost at stage 1");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_screen_x) && $stable(o_vertex_color))
        else $error("stalled output transaction changed");

endmodule
